// ===== hdl/dshot_frame_pulse_encoder_defines.svh =====
// Assertion macros shared by the encoder's RTL.
`ifndef DSHOT_FRAME_PULSE_ENCODER_DEFINES_SVH
`define DSHOT_FRAME_PULSE_ENCODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DSFE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DSFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/dsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// DSHOT frame encoder package
// Shared constants, types and the frame builder for the encoder.
// ----------------------------------------------------------------------------
package dsfe_pkg;

	localparam int LANES        = 6;
	localparam int FRAME_BITS   = 16;
	localparam int CMD_W        = 11;
	localparam int IN_W         = 16;
	localparam int TICK_W       = 16;
	localparam int ACT_W        = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_INDEX_W  = 2;
	localparam int CMD_SHIFT    = 5;
	localparam logic [3:0] CRC_MASK = 4'h0f;
	localparam int BIT_CNT_W    = $clog2(FRAME_BITS);
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [ACT_W-1:0]  ACTIVE_RST = ACT_W'(6);
	localparam logic [CMD_W-1:0]  MAX_CMD_RST = CMD_W'(2047);
	localparam logic [TICK_W-1:0] SHORT_RST  = TICK_W'(375);
	localparam logic [TICK_W-1:0] LONG_RST   = TICK_W'(750);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ACTIVE_CHANNELS = 2'd0,
		REG_MAX_COMMAND     = 2'd1,
		REG_SHORT_TICKS     = 2'd2,
		REG_LONG_TICKS      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [ACT_W-1:0]  active_channels;
		logic [CMD_W-1:0]  max_command;
		logic [TICK_W-1:0] short_pulse_ticks;
		logic [TICK_W-1:0] long_pulse_ticks;
	} cfg_t;

	typedef struct packed {
		logic                                 err;
		logic [LANES-1:0]                     act;
		logic [LANES-1:0][FRAME_BITS-1:0]     frame;
	} job_t;

	function automatic logic [FRAME_BITS-1:0] make_frame(input logic [CMD_W-1:0] cmd);
		logic [FRAME_BITS-1:0] data;
		logic [3:0]            crc;
		data = {cmd, {CMD_SHIFT{1'b0}}};
		crc  = (data[7:4] ^ data[11:8] ^ data[15:12]) & CRC_MASK;
		return {data[FRAME_BITS-1:4], crc};
	endfunction

endpackage

// ===== hdl/dsfe_front.sv =====
// ----------------------------------------------------------------------------
// DSHOT encoder front end
// Checks the active commands against the limit and builds each lane's frame.
// ----------------------------------------------------------------------------
module dsfe_front (
	input  logic [dsfe_pkg::LANES-1:0][dsfe_pkg::IN_W-1:0] commands,
	input  dsfe_pkg::cfg_t                                  cfg,
	output dsfe_pkg::job_t                                  job
);
	import dsfe_pkg::*;

	logic [ACT_W-1:0] n_active;
	logic [LANES-1:0] act;
	logic [LANES-1:0] over;

	assign n_active = (32'(cfg.active_channels) > LANES) ? ACT_W'(LANES) : cfg.active_channels;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			act[i]       = (i < 32'(n_active));
			over[i]      = act[i] && (commands[i] > {{(IN_W-CMD_W){1'b0}}, cfg.max_command});
			job.frame[i] = make_frame(commands[i][CMD_W-1:0]);
		end
		job.act = act;
		job.err = |over;
	end

endmodule

// ===== hdl/dsfe_queue.sv =====
// ----------------------------------------------------------------------------
// DSHOT encoder job queue
// Small first-in first-out store of classified jobs between front and back.
// ----------------------------------------------------------------------------
module dsfe_queue #(
	parameter int DEPTH = dsfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  dsfe_pkg::job_t wr_job,
	output logic           full,
	input  logic           rd_en,
	output logic           valid,
	output dsfe_pkg::job_t rd_job
);
	import dsfe_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign valid  = (count_q != '0);
	assign rd_job = store_q[rd_ptr_q];
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/dsfe_back.sv =====
// ----------------------------------------------------------------------------
// DSHOT encoder back end
// Shifts out one frame bit per beat and turns it into pulse lengths.
// ----------------------------------------------------------------------------
module dsfe_back (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              job_valid,
	input  dsfe_pkg::job_t                                    job,
	output logic                                              job_take,
	input  dsfe_pkg::cfg_t                                    cfg,
	input  logic                                              pop,
	output logic                                              empty,
	output logic [dsfe_pkg::LANES-1:0][dsfe_pkg::TICK_W-1:0]  pulses,
	output logic                                              range_error,
	output logic                                              last_bit
);
	import dsfe_pkg::*;

	logic                             busy_q;
	logic                             err_q;
	logic [LANES-1:0]                 act_q;
	logic [LANES-1:0][FRAME_BITS-1:0] shift_q;
	logic [BIT_CNT_W-1:0]             cnt_q;
	logic                             beat;
	logic                             is_last;

	assign is_last  = err_q || (cnt_q == BIT_CNT_W'(FRAME_BITS - 1));
	assign beat     = busy_q && pop;
	assign job_take = job_valid && (!busy_q || (beat && is_last));
	assign empty    = !busy_q;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (!act_q[i] || err_q) begin
				pulses[i] = '0;
			end else if (shift_q[i][FRAME_BITS-1]) begin
				pulses[i] = cfg.long_pulse_ticks;
			end else begin
				pulses[i] = cfg.short_pulse_ticks;
			end
		end
	end

	assign range_error = err_q;
	assign last_bit    = is_last;

	always_ff @(posedge clk) begin
		if (job_take) begin
			err_q   <= job.err;
			act_q   <= job.act;
			shift_q <= job.frame;
		end else if (beat) begin
			for (int i = 0; i < LANES; i++) begin
				shift_q[i] <= {shift_q[i][FRAME_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (job_take) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (beat) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

// ===== hdl/dshot_frame_pulse_encoder.sv =====
// An accepted command set goes through the job queue into the serialiser registers.
// Throughput: sixteen beats per set, one per cycle while pop is high, or one error beat.
// The rate is set by the bit serialiser in the back end, one frame bit per beat.
// A small job queue lets new command sets enter while beats are still being taken.
// Reset: configuration returns to its defaults and the queue and serialiser empty.
// ----------------------------------------------------------------------------
// DSHOT frame pulse encoder
// Encodes per-lane throttle commands into DSHOT frames and per-bit pulse lengths.
// ----------------------------------------------------------------------------
`include "dshot_frame_pulse_encoder_defines.svh"

module dshot_frame_pulse_encoder #(
	parameter int QUEUE_DEPTH = dsfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [dsfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [dsfe_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic [dsfe_pkg::IN_W-1:0]           command_lane0,
	input  logic [dsfe_pkg::IN_W-1:0]           command_lane1,
	input  logic [dsfe_pkg::IN_W-1:0]           command_lane2,
	input  logic [dsfe_pkg::IN_W-1:0]           command_lane3,
	input  logic [dsfe_pkg::IN_W-1:0]           command_lane4,
	input  logic [dsfe_pkg::IN_W-1:0]           command_lane5,
	output logic                                empty,
	input  logic                                pop,
	output logic [dsfe_pkg::TICK_W-1:0]         pulse_lane0,
	output logic [dsfe_pkg::TICK_W-1:0]         pulse_lane1,
	output logic [dsfe_pkg::TICK_W-1:0]         pulse_lane2,
	output logic [dsfe_pkg::TICK_W-1:0]         pulse_lane3,
	output logic [dsfe_pkg::TICK_W-1:0]         pulse_lane4,
	output logic [dsfe_pkg::TICK_W-1:0]         pulse_lane5,
	output logic                                range_error,
	output logic                                last_bit
);
	import dsfe_pkg::*;

	cfg_t                          cfg_q;
	logic [LANES-1:0][IN_W-1:0]    commands;
	logic [LANES-1:0][TICK_W-1:0]  pulses;
	job_t                          front_job;
	job_t                          queue_job;
	logic                          queue_valid;
	logic                          job_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_channels   <= ACTIVE_RST;
			cfg_q.max_command       <= MAX_CMD_RST;
			cfg_q.short_pulse_ticks <= SHORT_RST;
			cfg_q.long_pulse_ticks  <= LONG_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ACTIVE_CHANNELS: cfg_q.active_channels   <= cfg_data[ACT_W-1:0];
				REG_MAX_COMMAND:     cfg_q.max_command       <= cfg_data[CMD_W-1:0];
				REG_SHORT_TICKS:     cfg_q.short_pulse_ticks <= cfg_data[TICK_W-1:0];
				REG_LONG_TICKS:      cfg_q.long_pulse_ticks  <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign commands[0] = command_lane0;
	assign commands[1] = command_lane1;
	assign commands[2] = command_lane2;
	assign commands[3] = command_lane3;
	assign commands[4] = command_lane4;
	assign commands[5] = command_lane5;

	dsfe_front u_front (
		.commands (commands),
		.cfg      (cfg_q),
		.job      (front_job)
	);

	dsfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_job (front_job),
		.full   (full),
		.rd_en  (job_take),
		.valid  (queue_valid),
		.rd_job (queue_job)
	);

	dsfe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (queue_valid),
		.job         (queue_job),
		.job_take    (job_take),
		.cfg         (cfg_q),
		.pop         (pop),
		.empty       (empty),
		.pulses      (pulses),
		.range_error (range_error),
		.last_bit    (last_bit)
	);

	assign pulse_lane0 = pulses[0];
	assign pulse_lane1 = pulses[1];
	assign pulse_lane2 = pulses[2];
	assign pulse_lane3 = pulses[3];
	assign pulse_lane4 = pulses[4];
	assign pulse_lane5 = pulses[5];

	`DSFE_ASSERT_NOW(a_err_single, !empty && range_error, last_bit && (pulse_lane0 == '0) && (pulse_lane5 == '0), "Error beat must be final with zero pulses.")
	`DSFE_ASSERT_NEXT(a_frame_continues, !empty && pop && !last_bit, !empty, "Frame ended before its final bit.")
	`DSFE_ASSERT_NEXT(a_queue_drains, queue_valid && empty, !empty, "Serialiser idle while a job waits.")

endmodule

// ===== verif/dshot_frame_pulse_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// DSHOT frame pulse encoder testbench
// Drives throttle command sets and register settings into the encoder, predicts
// every pulse beat, including range errors, idle lanes and lane-count clamping,
// and compares each beat taken from the block with the oldest prediction.
// ----------------------------------------------------------------------------
module dshot_frame_pulse_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dsfe_pkg::*;

	localparam int IDLE_LIMIT      = 1000;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int HOLD_CYCLES     = 80;
	localparam int DRAIN_CYCLES    = 8;
	localparam int MAX_REPORTS     = 40;

	typedef logic [LANES-1:0][IN_W-1:0] cmd_set_t;

	typedef struct packed {
		logic [LANES-1:0][TICK_W-1:0] pulse;
		logic                         err;
		logic                         last;
	} pulse_beat_t;

	class pulse_scoreboard;
		logic [ACT_W-1:0]  lanes_on;
		logic [CMD_W-1:0]  cmd_limit;
		logic [TICK_W-1:0] zero_ticks;
		logic [TICK_W-1:0] one_ticks;
		pulse_beat_t       beats_due[$];
		int                mismatches;
		int                frames_sent;
		int                range_errors;
		int                beats_done;

		function new();
			lanes_on     = ACTIVE_RST;
			cmd_limit    = MAX_CMD_RST;
			zero_ticks   = SHORT_RST;
			one_ticks    = LONG_RST;
			mismatches   = 0;
			frames_sent  = 0;
			range_errors = 0;
			beats_done   = 0;
		endfunction

		function int live_lanes();
			return (lanes_on > LANES) ? LANES : int'(lanes_on);
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ACTIVE_CHANNELS: lanes_on   = data[ACT_W-1:0];
				REG_MAX_COMMAND:     cmd_limit  = data[CMD_W-1:0];
				REG_SHORT_TICKS:     zero_ticks = data[TICK_W-1:0];
				REG_LONG_TICKS:      one_ticks  = data[TICK_W-1:0];
			endcase
		endfunction

		function void note_command(cmd_set_t cmds);
			logic [LANES-1:0][FRAME_BITS-1:0] frame;
			logic [FRAME_BITS-1:0]            word;
			pulse_beat_t                      b;
			int                               n;
			n = live_lanes();
			frame = '0;
			for (int i = 0; i < n; i++) begin
				if (cmds[i] > cmd_limit) begin
					b = '0;
					b.err = 1'b1;
					b.last = 1'b1;
					beats_due.push_back(b);
					range_errors++;
					return;
				end
			end
			for (int i = 0; i < n; i++) begin
				word = {cmds[i][CMD_W-1:0], {CMD_SHIFT{1'b0}}};
				word[3:0] = word[15:12] ^ word[11:8] ^ word[7:4];
				frame[i] = word;
			end
			for (int k = 0; k < FRAME_BITS; k++) begin
				b = '0;
				for (int i = 0; i < n; i++)
					b.pulse[i] = frame[i][FRAME_BITS-1-k] ? one_ticks : zero_ticks;
				b.last = (k == FRAME_BITS - 1);
				beats_due.push_back(b);
			end
			frames_sent++;
		endfunction

		function void check_beat(pulse_beat_t got);
			pulse_beat_t want;
			beats_done++;
			if (beats_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: beat with nothing expected: lanes 5..0 %h err %b last %b",
						$time, got.pulse, got.err, got.last);
				return;
			end
			want = beats_due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: beat mismatch: expected lanes 5..0 %h err %b last %b, got %h err %b last %b",
						$time, want.pulse, want.err, want.last, got.pulse, got.err, got.last);
			end
		endfunction
	endclass

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   cfg_write   = 1'b0;
	cfg_reg_t               cfg_index   = REG_ACTIVE_CHANNELS;
	logic [CFG_DATA_W-1:0]  cfg_data    = '0;
	logic                   push        = 1'b0;
	logic                   pop         = 1'b0;
	cmd_set_t               cmd_drive   = '0;
	logic                   full;
	logic                   empty;
	logic [TICK_W-1:0]      pulse_lane0;
	logic [TICK_W-1:0]      pulse_lane1;
	logic [TICK_W-1:0]      pulse_lane2;
	logic [TICK_W-1:0]      pulse_lane3;
	logic [TICK_W-1:0]      pulse_lane4;
	logic [TICK_W-1:0]      pulse_lane5;
	logic                   range_error;
	logic                   last_bit;

	pulse_scoreboard sb = new();
	bit quiet = 1'b0;
	int hold_req = 0;
	int idle_cycles = 0;
	int items_sent = 0;

	dshot_frame_pulse_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.command_lane0(cmd_drive[0]),
		.command_lane1(cmd_drive[1]),
		.command_lane2(cmd_drive[2]),
		.command_lane3(cmd_drive[3]),
		.command_lane4(cmd_drive[4]),
		.command_lane5(cmd_drive[5]),
		.empty(empty),
		.pop(pop),
		.pulse_lane0(pulse_lane0),
		.pulse_lane1(pulse_lane1),
		.pulse_lane2(pulse_lane2),
		.pulse_lane3(pulse_lane3),
		.pulse_lane4(pulse_lane4),
		.pulse_lane5(pulse_lane5),
		.range_error(range_error),
		.last_bit(last_bit)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_beat(pulse_beat_t'({pulse_lane5, pulse_lane4, pulse_lane3, pulse_lane2,
				pulse_lane1, pulse_lane0, range_error, last_bit}));
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// The receiver takes beats with random stalls; a hold request makes it stop
	// taking beats for a long stretch so that the block fills and refuses input.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				pop = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				pop = 1'b0;
				stall_left--;
			end else begin
				pop = 1'b1;
				if (!quiet && $urandom_range(0, 9) == 0)
					stall_left = $urandom_range(1, 18);
			end
		end
	end

	task automatic drop_push();
		@(negedge clk);
		push = 1'b0;
	endtask

	task automatic send_command(cmd_set_t cmds);
		@(negedge clk);
		cmd_drive = cmds;
		push = 1'b1;
		do @(posedge clk); while (full);
		sb.note_command(cmds);
		items_sent++;
	endtask

	task automatic sender_gap();
		int n;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 18);
			drop_push();
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		drop_push();
		while (sb.beats_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_write = 1'b0;
		sb.set_reg(idx, data);
	endtask

	task automatic configure(logic [ACT_W-1:0] act, logic [CMD_W-1:0] mx,
		logic [TICK_W-1:0] sh, logic [TICK_W-1:0] lg);
		drain();
		repeat (4) @(posedge clk);
		write_reg(REG_ACTIVE_CHANNELS, {13'($urandom), act});
		write_reg(REG_MAX_COMMAND, {5'($urandom), mx});
		write_reg(REG_SHORT_TICKS, sh);
		write_reg(REG_LONG_TICKS, lg);
	endtask

	// Mostly in-range command sets; some push one active lane over the limit and
	// a few are wholly random. Idle lanes always carry random values.
	function automatic cmd_set_t random_commands();
		cmd_set_t c;
		int       n;
		int       mode;
		int       pick;
		n = sb.live_lanes();
		mode = $urandom_range(0, 99);
		for (int i = 0; i < LANES; i++) begin
			if (i >= n || mode >= 95)
				c[i] = 16'($urandom);
			else begin
				case ($urandom_range(0, 7))
					0:       c[i] = '0;
					1:       c[i] = IN_W'(sb.cmd_limit);
					default: c[i] = IN_W'($urandom_range(0, sb.cmd_limit));
				endcase
			end
		end
		if (mode >= 80 && mode < 95 && n > 0) begin
			pick = $urandom_range(0, n - 1);
			c[pick] = IN_W'($urandom_range(int'(sb.cmd_limit) + 1, 65535));
		end
		return c;
	endfunction

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		send_command('0);
		send_command({LANES{16'd2047}});
		send_command({16'h0123, 16'h07FE, 16'h0400, 16'h0001, 16'h02AA, 16'h0555});
		send_command({16'd2048, {5{16'd0}}});
		send_command({{5{16'd0}}, 16'hFFFF});
		send_command({LANES{16'hFFFF}});

		configure(3'd0, 11'd2047, 16'd375, 16'd750);
		send_command({LANES{16'hFFFF}});

		configure(3'd7, 11'd2047, 16'd375, 16'd750);
		send_command({16'd2048, {5{16'd0}}});
		send_command({LANES{16'd2047}});

		configure(3'd2, 11'd100, 16'd0, 16'hFFFF);
		send_command({{4{16'hFFFF}}, 16'd0, 16'd100});
		send_command({{4{16'hFFFF}}, 16'd101, 16'd0});
		send_command({{4{16'hFFFF}}, 16'd100, 16'd0});

		configure(3'd1, 11'd0, 16'hFFFF, 16'd0);
		send_command('0);
		send_command({{5{16'd0}}, 16'd1});
		send_command({{5{16'hFFFF}}, 16'd0});

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:          configure(3'd6, 11'd2047, 16'd0, 16'hFFFF);
				1:          configure(3'd1, 11'd0, 16'hFFFF, 16'd0);
				2:          configure(3'd7, 11'($urandom), 16'($urandom), 16'($urandom));
				3:          configure(3'd0, 11'($urandom), 16'($urandom), 16'($urandom));
				PHASES - 1: configure(3'd6, 11'd2047, 16'($urandom), 16'($urandom));
				default:    configure(3'($urandom_range(0, 7)),
					($urandom_range(0, 3) == 0) ? 11'd2047 : 11'($urandom),
					16'($urandom), 16'($urandom));
			endcase
			quiet = (p == PHASES - 1);
			if (p == 4)
				hold_req = HOLD_CYCLES;
			for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
				if (p == 6 && j == ITEMS_PER_PHASE / 2)
					drain();
				send_command(random_commands());
				if (p != 4)
					sender_gap();
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d command sets: %0d encoded frames, %0d range errors, %0d beats checked.",
			items_sent, sb.frames_sent, sb.range_errors, sb.beats_done);
		$display("Register settings spanned %0d phases, lane counts 0 to 7, tick extremes and a full stall.",
			PHASES + 4);
		if (sb.mismatches == 0 && sb.beats_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
